/* rtl/sdhc_pkg.sv */
// shared types and constants of the slip decoder with hash check
package sdhc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CAP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam int POS_WIDTH   = 16;
  localparam int ADDR_WIDTH  = 2;
  localparam int DATA_WIDTH  = 32;

  localparam logic [7:0]  SLIP_END     = 8'hC0;
  localparam logic [7:0]  SLIP_ESC     = 8'hDB;
  localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
  localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
  localparam logic [31:0] HASH_MUL     = 32'd1664525;
  localparam logic [31:0] HASH_ADD     = 32'd1013904223;
  localparam logic [CAP_WIDTH-1:0] MIN_FRAME  = CAP_WIDTH'(5);
  localparam logic [CAP_WIDTH-1:0] HASH_BYTES = CAP_WIDTH'(4);
  localparam logic [CAP_WIDTH-1:0] COUNT_MAX  =
    CAP_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(256);
  localparam logic [ADDR_WIDTH-1:0]  REG_FRAME_LIMIT = '0;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_SHORT    = 3'd2,
    KIND_BADHASH  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data_byte;
    logic [POS_WIDTH-1:0] position;
    logic [POS_WIDTH-1:0] payload_length;
  } result_t;

endpackage

/* rtl/sdhc_front.sv */
// front part: escape handling, byte classification and command queue
module sdhc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          full,
  output logic          cmd_valid,
  output sdhc_pkg::cmd_t cmd,
  input  logic          cmd_take
);
  import sdhc_pkg::*;

  logic       escape_pending;
  logic       accept;
  logic       enq;
  cmd_t       enq_cmd;
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign accept    = push && !full;

  always_comb begin
    enq           = 1'b0;
    enq_cmd.op    = OP_DATA;
    enq_cmd.value = rx_byte;
    if (accept && rx_byte != SLIP_ESC) begin
      enq = 1'b1;
      if (escape_pending) begin
        if (rx_byte == SLIP_ESC_END) begin
          enq_cmd.value = SLIP_END;
        end else if (rx_byte == SLIP_ESC_ESC) begin
          enq_cmd.value = SLIP_ESC;
        end
      end else if (rx_byte == SLIP_END) begin
        enq_cmd.op = OP_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      wr_ptr         <= 1'b0;
      rd_ptr         <= 1'b0;
      fill           <= 2'd0;
    end else begin
      if (accept) begin
        escape_pending <= (rx_byte == SLIP_ESC);
      end
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, enq} - {1'b0, cmd_take};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

endmodule

/* rtl/sdhc_back.sv */
// back part: frame count, hash delay line, frame check and result queue
module sdhc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  sdhc_pkg::cmd_t                     cmd,
  output logic                               cmd_take,
  input  logic [sdhc_pkg::LIMIT_WIDTH-1:0]   frame_limit,
  output logic                               empty,
  input  logic                               pop,
  output sdhc_pkg::result_t                  result
);
  import sdhc_pkg::*;

  logic [COUNT_WIDTH-1:0] byte_count;
  logic [31:0]            running_hash;
  logic [7:0]             recent_bytes [4];
  logic [CAP_WIDTH-1:0]   count_ext;
  logic [CAP_WIDTH-1:0]   limit_ext;
  logic [CAP_WIDTH-1:0]   cap;
  logic [31:0]            tag;
  logic [31:0]            hash_next;
  logic                   clear;
  logic                   advance;
  result_t                res;
  result_t                slots [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  logic                   res_full;
  logic                   deq;

  assign res_full  = (fill == 2'd2);
  assign empty     = (fill == 2'd0);
  assign result    = slots[rd_ptr];
  assign deq       = pop && !empty;
  assign cmd_take  = cmd_valid && !res_full;
  assign count_ext = CAP_WIDTH'(byte_count);
  assign limit_ext = CAP_WIDTH'(frame_limit);
  assign cap       = (limit_ext < COUNT_MAX) ? limit_ext : COUNT_MAX;
  assign tag       = {recent_bytes[3], recent_bytes[2], recent_bytes[1], recent_bytes[0]};
  assign hash_next = running_hash * HASH_MUL + {24'd0, recent_bytes[0]} + HASH_ADD;

  always_comb begin
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.position       = '0;
    res.payload_length = '0;
    clear              = 1'b0;
    advance            = 1'b0;
    unique case (cmd.op)
      OP_END: begin
        clear = 1'b1;
        if (count_ext < MIN_FRAME) begin
          res.kind = KIND_SHORT;
        end else if (tag == running_hash) begin
          res.kind           = KIND_GOOD;
          res.payload_length = POS_WIDTH'(count_ext - HASH_BYTES);
        end else begin
          res.kind = KIND_BADHASH;
        end
      end
      OP_DATA: begin
        if (count_ext >= cap) begin
          clear    = 1'b1;
          res.kind = KIND_OVERFLOW;
        end else begin
          advance       = 1'b1;
          res.data_byte = cmd.value;
          res.position  = POS_WIDTH'(byte_count);
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_hash <= '0;
      for (int i = 0; i < 4; i++) begin
        recent_bytes[i] <= 8'd0;
      end
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (cmd_take) begin
        if (clear) begin
          byte_count   <= '0;
          running_hash <= '0;
          for (int i = 0; i < 4; i++) begin
            recent_bytes[i] <= 8'd0;
          end
        end else if (advance) begin
          if (count_ext >= HASH_BYTES) begin
            running_hash <= hash_next;
          end
          recent_bytes[0] <= recent_bytes[1];
          recent_bytes[1] <= recent_bytes[2];
          recent_bytes[2] <= recent_bytes[3];
          recent_bytes[3] <= cmd.value;
          byte_count      <= byte_count + COUNT_WIDTH'(1);
        end
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, cmd_take} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      slots[wr_ptr] <= res;
    end
  end

endmodule

/* rtl/slip_decoder_with_hash_check_unit.sv */
// top level of the slip decoder with frame hash check
//
// Input queue side: a raw serial byte is a request on rx_byte, taken when
// push is high and full is low. Result queue side: the oldest result sits on
// kind, data_byte, position and payload_length while empty is low, and is
// taken when pop is high. Each byte gives at most one result (escape bytes
// give none); a frame end gives good, too short or hash mismatch.
// A taken request passes the command queue of the front part and then the
// result queue of the back part before its result reaches the result ports.
// Throughput: one request per cycle while full is low, as the hash is updated
// in the same cycle in which each command is taken by the back part.
// The frame limit is written through the APB-style port at address 0.
// Reset clears both queues, the escape flag, count, hash and delay line,
// and sets the frame limit to 256. When the receiver stops popping, the
// result queue fills, the back part stops, the command queue fills and
// full rises; nothing is lost.
module slip_decoder_with_hash_check_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        rx_byte,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        kind,
  output logic [7:0]                        data_byte,
  output logic [sdhc_pkg::POS_WIDTH-1:0]    position,
  output logic [sdhc_pkg::POS_WIDTH-1:0]    payload_length,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdhc_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [sdhc_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [sdhc_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                              pready
);
  import sdhc_pkg::*;

  logic                   cmd_valid;
  cmd_t                   cmd;
  logic                   cmd_take;
  result_t                result;
  logic [LIMIT_WIDTH-1:0] frame_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_FRAME_LIMIT) begin
      frame_limit <= pwdata[LIMIT_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FRAME_LIMIT) begin
      prdata = DATA_WIDTH'(frame_limit);
    end
  end

  sdhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sdhc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .frame_limit (frame_limit),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  assign kind           = result.kind;
  assign data_byte      = result.data_byte;
  assign position       = result.position;
  assign payload_length = result.payload_length;

endmodule

/* bench/slip_frame_checker.sv */
`timescale 1ns / 1ps
// decoder predictor and result comparison for the slip decoder with hash check
module slip_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [7:0]                      rx_byte,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [2:0]                      kind,
  input  logic [7:0]                      data_byte,
  input  logic [sdhc_pkg::POS_WIDTH-1:0]  position,
  input  logic [sdhc_pkg::POS_WIDTH-1:0]  payload_length,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdhc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [sdhc_pkg::DATA_WIDTH-1:0] pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              outstanding
);
  import sdhc_pkg::*;

  logic                   esc_armed;
  logic [COUNT_WIDTH-1:0] frame_len;
  logic [31:0]            frame_hash;
  logic [7:0]             tail [4];
  logic [LIMIT_WIDTH-1:0] limit_copy;
  result_t                decoded_results [$];
  result_t                head;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    mismatches++;
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, wanted);
  endtask

  task automatic clear_frame_state();
    frame_len  = '0;
    frame_hash = '0;
    foreach (tail[i]) tail[i] = '0;
  endtask

  task automatic decode_slip_byte(input logic [7:0] raw);
    logic [7:0]           c;
    logic [CAP_WIDTH-1:0] cap;
    result_t              r;
    c = raw;
    r = '0;
    if (raw == SLIP_ESC) begin
      esc_armed = 1'b1;
      return;
    end
    if (esc_armed) begin
      if (raw == SLIP_ESC_END) c = SLIP_END;
      else if (raw == SLIP_ESC_ESC) c = SLIP_ESC;
      esc_armed = 1'b0;
    end else if (raw == SLIP_END) begin
      if (CAP_WIDTH'(frame_len) < MIN_FRAME) begin
        r.kind = KIND_SHORT;
      end else if ({tail[3], tail[2], tail[1], tail[0]} == frame_hash) begin
        r.kind = KIND_GOOD;
        r.payload_length = POS_WIDTH'(CAP_WIDTH'(frame_len) - HASH_BYTES);
      end else begin
        r.kind = KIND_BADHASH;
      end
      decoded_results.push_back(r);
      clear_frame_state();
      return;
    end
    cap = (CAP_WIDTH'(limit_copy) < COUNT_MAX) ? CAP_WIDTH'(limit_copy) : COUNT_MAX;
    if (CAP_WIDTH'(frame_len) >= cap) begin
      r.kind = KIND_OVERFLOW;
      decoded_results.push_back(r);
      clear_frame_state();
      return;
    end
    if (CAP_WIDTH'(frame_len) >= HASH_BYTES)
      frame_hash = frame_hash * HASH_MUL + 32'(tail[0]) + HASH_ADD;
    tail[0] = tail[1];
    tail[1] = tail[2];
    tail[2] = tail[3];
    tail[3] = c;
    r.kind      = KIND_DATA;
    r.data_byte = c;
    r.position  = POS_WIDTH'(frame_len);
    decoded_results.push_back(r);
    frame_len = frame_len + COUNT_WIDTH'(1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_copy = LIMIT_RESET;
      esc_armed  = 1'b0;
      clear_frame_state();
      decoded_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_FRAME_LIMIT)
        limit_copy = pwdata[LIMIT_WIDTH-1:0];
      if (push && !full)
        decode_slip_byte(rx_byte);
      if (pop && !empty) begin
        if (decoded_results.size() == 0) begin
          report_mismatch("result with nothing waiting, kind", 32'(kind), 32'(0));
        end else begin
          head = decoded_results.pop_front();
          if (kind !== head.kind)
            report_mismatch("kind", 32'(kind), 32'(head.kind));
          if (data_byte !== head.data_byte)
            report_mismatch("data_byte", 32'(data_byte), 32'(head.data_byte));
          if (position !== head.position)
            report_mismatch("position", 32'(position), 32'(head.position));
          if (payload_length !== head.payload_length)
            report_mismatch("payload_length", 32'(payload_length),
                            32'(head.payload_length));
        end
      end
    end
    outstanding <= decoded_results.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the slip decoder with hash check
module tb_top;
  import sdhc_pkg::*;

  typedef logic [7:0] bytes_t [$];

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  push    = 1'b0;
  logic [7:0]            rx_byte = '0;
  logic                  pop     = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr   = '0;
  logic [DATA_WIDTH-1:0] pwdata  = '0;
  logic                  full;
  logic                  empty;
  logic [2:0]            kind;
  logic [7:0]            data_byte;
  logic [POS_WIDTH-1:0]  position;
  logic [POS_WIDTH-1:0]  payload_length;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;

  int                     hold_cycles   = 0;
  int                     stall_total   = 0;
  bit                     fast_mode     = 1'b0;
  int                     bytes_sent    = 0;
  int                     frames_sent   = 0;
  int                     settings_used = 0;
  logic [LIMIT_WIDTH-1:0] cur_limit     = LIMIT_RESET;

  slip_decoder_with_hash_check_unit u_top (.*);

  slip_frame_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : receiver
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        stall_total += hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = fast_mode ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic send_raw(input logic [7:0] b);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // stuffs special bytes, sometimes escapes a plain byte that passes raw
  task automatic send_frame(input bytes_t body);
    foreach (body[i]) begin
      if (body[i] == SLIP_END) begin
        send_raw(SLIP_ESC);
        send_raw(SLIP_ESC_END);
      end else if (body[i] == SLIP_ESC) begin
        send_raw(SLIP_ESC);
        send_raw(SLIP_ESC_ESC);
      end else if (body[i] != SLIP_ESC_END && body[i] != SLIP_ESC_ESC &&
                   $urandom_range(0, 9) == 0) begin
        send_raw(SLIP_ESC);
        send_raw(body[i]);
      end else begin
        send_raw(body[i]);
      end
    end
    send_raw(SLIP_END);
    frames_sent++;
  endtask

  function automatic bytes_t seal(input bytes_t payload);
    logic [31:0] h;
    bytes_t      f;
    h = '0;
    f = payload;
    foreach (payload[i]) h = h * HASH_MUL + 32'(payload[i]) + HASH_ADD;
    f.push_back(h[7:0]);
    f.push_back(h[15:8]);
    f.push_back(h[23:16]);
    f.push_back(h[31:24]);
    return f;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return SLIP_END;
      1: return SLIP_ESC;
      2: return SLIP_ESC_END;
      3: return SLIP_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_limit(input logic [LIMIT_WIDTH-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FRAME_LIMIT;
    pwdata  <= {16'($urandom_range(0, 65535)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_limit = v;
    settings_used++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_frame();
    bytes_t body;
    int     sel;
    int     n;
    int     lim;
    int     top;
    int     idx;
    sel = $urandom_range(0, 99);
    lim = int'(cur_limit);
    fast_mode = ($urandom_range(0, 3) == 0);
    top = (lim > 4) ? lim - 4 : 1;
    if (top > 24) top = 24;
    n = $urandom_range(1, top);
    if (lim > 40 && $urandom_range(0, 19) == 0)
      n = $urandom_range(25, (lim - 4 > 200) ? 200 : lim - 4);
    if (sel < 60) begin
      repeat (n) body.push_back(pick_byte());
      send_frame(seal(body));
    end else if (sel < 75) begin
      // good frame with one bit flipped
      repeat (n) body.push_back(pick_byte());
      body = seal(body);
      idx = $urandom_range(0, body.size() - 1);
      body[idx] = body[idx] ^ (8'd1 << $urandom_range(0, 7));
      send_frame(body);
    end else if (sel < 85) begin
      repeat ($urandom_range(0, 4)) body.push_back(pick_byte());
      send_frame(body);
    end else if (sel < 93) begin
      n = (lim <= 64) ? lim + $urandom_range(1, 3) : n;
      repeat (n) body.push_back(pick_byte());
      send_frame(body);
    end else begin
      repeat ($urandom_range(1, 8)) send_raw(pick_byte());
    end
  endtask

  initial begin : stimulus
    bytes_t directed;
    bytes_t body;
    int     limits [$];
    int     start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frame, every escape form, double escape, escaped end, bare dc and dd
    directed = '{SLIP_END, SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC,
                 SLIP_ESC, 8'h41, SLIP_ESC, SLIP_ESC, SLIP_ESC_END, SLIP_ESC,
                 SLIP_END, 8'h00, 8'hFF, SLIP_ESC_END, SLIP_ESC_ESC, SLIP_END,
                 8'h01, 8'h02, SLIP_END};
    foreach (directed[i]) send_raw(directed[i]);
    body = '{8'h80};
    send_frame(seal(body));

    limits = '{5, 0, 65535, 3, $urandom_range(6, 64), 1000,
               $urandom_range(5, 300), 256};
    foreach (limits[p]) begin
      drain_results();
      write_limit(LIMIT_WIDTH'(limits[p]));
      if (p == 2) begin
        // hold the result side while requests keep coming
        hold_cycles = 300;
        fast_mode   = 1'b1;
        repeat (6) begin
          body.delete();
          repeat (12) body.push_back(pick_byte());
          send_frame(seal(body));
        end
        fast_mode = 1'b0;
      end
      start = bytes_sent;
      while (bytes_sent - start < 120) send_random_frame();
    end
    fast_mode = 1'b0;
    drain_results();

    $display("run: %0d line bytes, %0d frames, %0d frame limit settings incl. 0 and 65535",
             bytes_sent, frames_sent, settings_used);
    $display("run: result side held for %0d cycles in total, %0d mismatches",
             stall_total, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
